// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, muted while reset is high
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cht_pkg.sv =====
// ---------------------------------------------------------------------------
// cht_pkg
// shared types and constants of the cubic homing trajectory block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cht_pkg;

   localparam int FRAC = 16;

   localparam logic [22:0]        RATE_RST = 23'd524288;
   localparam logic signed [25:0] TREL_RST = 26'sd6553600;
   localparam logic signed [25:0] TPRS_RST = -26'sd1310720;
   localparam logic [16:0]        TICK_RST = 17'd655;

   typedef enum logic [1:0] {
      CSR_RATE,
      CSR_TREL,
      CSR_TPRS,
      CSR_TICK
   } csr_idx_type;

   typedef enum logic [4:0] {
      STEP_DELTA,
      STEP_DIV_DUR,
      STEP_DIV_C1,
      STEP_DIV_C2,
      STEP_DIV_D1,
      STEP_DIV_D2,
      STEP_DIV_D3,
      STEP_PLAN,
      STEP_EDGE,
      STEP_MUL_T2,
      STEP_MUL_T3,
      STEP_MUL_M1,
      STEP_MUL_M2,
      STEP_MUL_M3,
      STEP_MUL_M4,
      STEP_EVAL,
      STEP_OUT
   } step_type;

   typedef struct packed {
      step_type step;
      logic     go;
      logic     load;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic active;
      logic edge_hit;
      logic timeout;
      logic done;
   } status_type;

endpackage

// ===== sv/cht_div.sv =====
// ---------------------------------------------------------------------------
// cht_div
// restoring divider, 64 bit dividend by 32 bit divisor, one bit a cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = ~diff[33];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/cht_mul.sv =====
// ---------------------------------------------------------------------------
// cht_mul
// shift and add multiplier, 64 by 64 bits unsigned, one bit a cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  mcand,
   input  logic [63:0]  mplier,
   output logic         done,
   output logic [127:0] prod
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] mcd_ff, mcd_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [64:0] sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcd_ff} : 65'd0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mcd_in  = mcd_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mcd_in  = mcand;
         hi_in   = '0;
         lo_in   = mplier;
      end else if (busy_ff) begin
         hi_in  = sum[64:1];
         lo_in  = {sum[0], lo_ff[63:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcd_ff <= mcd_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

// ===== sv/cht_dp.sv =====
// ---------------------------------------------------------------------------
// cht_dp
// datapath: settings, plan state, divider and multiplier, result registers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cht_dp (
   input  logic                clock,
   input  logic                reset,
   input  cht_pkg::cmd_type    cmd,
   output cht_pkg::status_type st,
   input  logic                req_op,
   input  logic                req_switch_level,
   input  logic signed [31:0]  req_joint_position,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [25:0]         csr_data,
   output logic signed [31:0]  rsp_position,
   output logic signed [31:0]  rsp_velocity,
   output logic                rsp_busy_res,
   output logic                rsp_homed,
   output logic                rsp_clear_encoder
);

   localparam logic [61:0] TERM_LIM = 62'd1 << 61;

   function automatic logic [61:0] mag_of(input logic [127:0] p);
      if (p[127:64] != '0)
         return TERM_LIM;
      return 62'(p[63:cht_pkg::FRAC]);
   endfunction

   function automatic logic signed [62:0] signed_of(input logic [61:0] m, input logic neg);
      logic signed [62:0] v;
      v = $signed({1'b0, m});
      return neg ? -v : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648)
         return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] coef(input logic [63:0] q, input logic sat,
                                               input logic neg);
      logic [30:0] m;
      m = (sat || q[63:31] != '0) ? '1 : q[30:0];
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   logic [22:0]        rate_ff, rate_in;
   logic signed [25:0] trel_ff, trel_in;
   logic signed [25:0] tprs_ff, tprs_in;
   logic [16:0]        tick_ff, tick_in;

   logic               op_ff, op_in;
   logic               lvl_ff, lvl_in;
   logic signed [31:0] pos_ff, pos_in;

   logic               active_ff, active_in;
   logic               lap_ff, lap_in;
   logic               hdone_ff, hdone_in;
   logic               clr_ff, clr_in;
   logic signed [31:0] start_ff, start_in;
   logic signed [31:0] c_ff, c_in;
   logic signed [31:0] d_ff, d_in;
   logic [31:0]        dur_ff, dur_in;
   logic [31:0]        el_ff, el_in;
   logic signed [31:0] hp_ff, hp_in;
   logic signed [31:0] hv_ff, hv_in;

   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [63:0]        q_ff, q_in;
   logic               qsat_ff, qsat_in;
   logic [63-cht_pkg::FRAC:0] t2_ff, t2_in;
   logic [61:0]        t3_ff, t3_in;
   logic signed [62:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;

   logic signed [31:0] rpos_ff, rpos_in;
   logic signed [31:0] rvel_ff, rvel_in;
   logic               rbusy_ff, rbusy_in;
   logic               rhomed_ff, rhomed_in;
   logic               rclr_ff, rclr_in;

   logic               div_start, div_done;
   logic [63:0]        div_dividend, div_q;
   logic [31:0]        div_divisor;
   logic               mul_start, mul_done;
   logic [63:0]        mul_a, mul_b;
   logic [127:0]       mul_p;

   logic [32:0]        el_sum;
   logic signed [25:0] tgt;
   logic signed [32:0] delta;
   logic [33:0]        mag3;
   logic [31:0]        cmag, dmag;
   logic signed [63:0] psum, vsum;
   logic               q_big;

   assign el_sum = {1'b0, el_ff} + {16'd0, tick_ff};
   assign tgt    = lvl_ff ? trel_ff : tprs_ff;
   assign delta  = {{7{tgt[25]}}, tgt} - {pos_ff[31], pos_ff};
   assign mag3   = {2'b00, mag_ff} + {1'b0, mag_ff, 1'b0};
   assign cmag   = c_ff[31] ? 32'(-c_ff) : c_ff;
   assign dmag   = d_ff[31] ? 32'(-d_ff) : d_ff;
   assign psum   = 64'(start_ff) + 64'(m1_ff) + 64'(m2_ff);
   assign vsum   = 64'(m3_ff) + 64'(m4_ff);
   assign q_big  = div_q[63:64-cht_pkg::FRAC] != '0;

   always_comb begin
      div_start    = 1'b0;
      mul_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = dur_ff;
      mul_a        = '0;
      mul_b        = '0;
      case (cmd.step)
         cht_pkg::STEP_DIV_DUR: begin
            div_start    = cmd.go;
            div_dividend = 64'(mag_ff) << cht_pkg::FRAC;
            div_divisor  = (rate_ff == '0) ? 32'd1 : 32'(rate_ff);
         end
         cht_pkg::STEP_DIV_C1: begin
            div_start    = cmd.go;
            div_dividend = 64'(mag3) << cht_pkg::FRAC;
         end
         cht_pkg::STEP_DIV_D1: begin
            div_start    = cmd.go;
            div_dividend = 64'({mag_ff, 1'b0}) << cht_pkg::FRAC;
         end
         cht_pkg::STEP_DIV_C2, cht_pkg::STEP_DIV_D2, cht_pkg::STEP_DIV_D3: begin
            div_start    = cmd.go;
            div_dividend = q_ff << cht_pkg::FRAC;
         end
         cht_pkg::STEP_MUL_T2: begin
            mul_start = cmd.go;
            mul_a     = 64'(el_ff);
            mul_b     = 64'(el_ff);
         end
         cht_pkg::STEP_MUL_T3: begin
            mul_start = cmd.go;
            mul_a     = 64'(t2_ff);
            mul_b     = 64'(el_ff);
         end
         cht_pkg::STEP_MUL_M1: begin
            mul_start = cmd.go;
            mul_a     = 64'(cmag);
            mul_b     = 64'(t2_ff);
         end
         cht_pkg::STEP_MUL_M2: begin
            mul_start = cmd.go;
            mul_a     = 64'(dmag);
            mul_b     = 64'(t3_ff);
         end
         cht_pkg::STEP_MUL_M3: begin
            mul_start = cmd.go;
            mul_a     = 64'({cmag, 1'b0});
            mul_b     = 64'(el_ff);
         end
         cht_pkg::STEP_MUL_M4: begin
            mul_start = cmd.go;
            mul_a     = 64'({dmag, 1'b0}) + 64'(dmag);
            mul_b     = 64'(t2_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rate_in   = rate_ff;
      trel_in   = trel_ff;
      tprs_in   = tprs_ff;
      tick_in   = tick_ff;
      op_in     = op_ff;
      lvl_in    = lvl_ff;
      pos_in    = pos_ff;
      active_in = active_ff;
      lap_in    = lap_ff;
      hdone_in  = hdone_ff;
      clr_in    = clr_ff;
      start_in  = start_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      dur_in    = dur_ff;
      el_in     = el_ff;
      hp_in     = hp_ff;
      hv_in     = hv_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      q_in      = q_ff;
      qsat_in   = qsat_ff;
      t2_in     = t2_ff;
      t3_in     = t3_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      m3_in     = m3_ff;
      m4_in     = m4_ff;
      rpos_in   = rpos_ff;
      rvel_in   = rvel_ff;
      rbusy_in  = rbusy_ff;
      rhomed_in = rhomed_ff;
      rclr_in   = rclr_ff;

      if (csr_valid) begin
         case (cht_pkg::csr_idx_type'(csr_index))
            cht_pkg::CSR_RATE: rate_in = csr_data[22:0];
            cht_pkg::CSR_TREL: trel_in = csr_data;
            cht_pkg::CSR_TPRS: tprs_in = csr_data;
            cht_pkg::CSR_TICK: tick_in = csr_data[16:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         op_in  = req_op;
         lvl_in = req_switch_level;
         pos_in = req_joint_position;
         clr_in = 1'b0;
         if (!req_op)
            hdone_in = 1'b0;
         if (req_op && active_ff)
            el_in = el_sum[32] ? '1 : el_sum[31:0];
      end

      if (cmd.go) begin
         case (cmd.step)
            cht_pkg::STEP_DELTA: begin
               neg_in = delta[32];
               mag_in = delta[32] ? 32'(-delta) : delta[31:0];
            end
            cht_pkg::STEP_PLAN: begin
               active_in = 1'b1;
               lap_in    = lvl_ff;
               start_in  = pos_ff;
               el_in     = '0;
               hp_in     = pos_ff;
               hv_in     = '0;
            end
            cht_pkg::STEP_EDGE: begin
               clr_in    = 1'b1;
               active_in = 1'b0;
               hdone_in  = 1'b1;
               hp_in     = '0;
               hv_in     = '0;
            end
            cht_pkg::STEP_EVAL: begin
               hp_in = sat32(psum);
               hv_in = sat32(vsum);
            end
            cht_pkg::STEP_OUT: begin
               rpos_in   = hp_ff;
               rvel_in   = hv_ff;
               rbusy_in  = active_ff;
               rhomed_in = hdone_ff;
               rclr_in   = clr_ff;
            end
            default: begin
            end
         endcase
      end

      if (div_done) begin
         case (cmd.step)
            cht_pkg::STEP_DIV_DUR: dur_in = (div_q[63:32] != '0) ? '1 : div_q[31:0];
            cht_pkg::STEP_DIV_C1, cht_pkg::STEP_DIV_D1: begin
               q_in    = div_q;
               qsat_in = q_big;
            end
            cht_pkg::STEP_DIV_D2: begin
               q_in    = div_q;
               qsat_in = qsat_ff | q_big;
            end
            cht_pkg::STEP_DIV_C2:
               c_in = (dur_ff == '0) ? '0 : coef(div_q, qsat_ff, neg_ff);
            cht_pkg::STEP_DIV_D3:
               d_in = (dur_ff == '0) ? '0 : coef(div_q, qsat_ff, ~neg_ff);
            default: begin
            end
         endcase
      end

      if (mul_done) begin
         case (cmd.step)
            cht_pkg::STEP_MUL_T2: t2_in = mul_p[63:cht_pkg::FRAC];
            cht_pkg::STEP_MUL_T3: t3_in = mag_of(mul_p);
            cht_pkg::STEP_MUL_M1: m1_in = signed_of(mag_of(mul_p), c_ff[31]);
            cht_pkg::STEP_MUL_M2: m2_in = signed_of(mag_of(mul_p), d_ff[31]);
            cht_pkg::STEP_MUL_M3: m3_in = signed_of(mag_of(mul_p), c_ff[31]);
            cht_pkg::STEP_MUL_M4: m4_in = signed_of(mag_of(mul_p), d_ff[31]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= cht_pkg::RATE_RST;
         trel_ff   <= cht_pkg::TREL_RST;
         tprs_ff   <= cht_pkg::TPRS_RST;
         tick_ff   <= cht_pkg::TICK_RST;
         active_ff <= 1'b0;
         lap_ff    <= 1'b0;
         hdone_ff  <= 1'b0;
         clr_ff    <= 1'b0;
         start_ff  <= '0;
         c_ff      <= '0;
         d_ff      <= '0;
         dur_ff    <= '0;
         el_ff     <= '0;
         hp_ff     <= '0;
         hv_ff     <= '0;
      end else begin
         rate_ff   <= rate_in;
         trel_ff   <= trel_in;
         tprs_ff   <= tprs_in;
         tick_ff   <= tick_in;
         active_ff <= active_in;
         lap_ff    <= lap_in;
         hdone_ff  <= hdone_in;
         clr_ff    <= clr_in;
         start_ff  <= start_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         dur_ff    <= dur_in;
         el_ff     <= el_in;
         hp_ff     <= hp_in;
         hv_ff     <= hv_in;
      end
      op_ff     <= op_in;
      lvl_ff    <= lvl_in;
      pos_ff    <= pos_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      q_ff      <= q_in;
      qsat_ff   <= qsat_in;
      t2_ff     <= t2_in;
      t3_ff     <= t3_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      m3_ff     <= m3_in;
      m4_ff     <= m4_in;
      rpos_ff   <= rpos_in;
      rvel_ff   <= rvel_in;
      rbusy_ff  <= rbusy_in;
      rhomed_ff <= rhomed_in;
      rclr_ff   <= rclr_in;
   end

   cht_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   cht_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_p)
   );

   assign st.op       = op_ff;
   assign st.active   = active_ff;
   assign st.edge_hit = lap_ff & ~lvl_ff;
   assign st.timeout  = el_ff >= dur_ff;
   assign st.done     = div_done | mul_done;

   assign rsp_position      = rpos_ff;
   assign rsp_velocity      = rvel_ff;
   assign rsp_busy_res      = rbusy_ff;
   assign rsp_homed         = rhomed_ff;
   assign rsp_clear_encoder = rclr_ff;

endmodule

// ===== sv/cht_ctrl.sv =====
// ---------------------------------------------------------------------------
// cht_ctrl
// sequencer: takes a beat, steps the datapath through plan, edge, bare output or evaluation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cht_pkg::cmd_type    cmd,
   input  cht_pkg::status_type st
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_ISSUE,
      S_WAIT
   } state_type;

   function automatic cht_pkg::step_type next_step(input cht_pkg::step_type s);
      case (s)
         cht_pkg::STEP_DELTA:   return cht_pkg::STEP_DIV_DUR;
         cht_pkg::STEP_DIV_DUR: return cht_pkg::STEP_DIV_C1;
         cht_pkg::STEP_DIV_C1:  return cht_pkg::STEP_DIV_C2;
         cht_pkg::STEP_DIV_C2:  return cht_pkg::STEP_DIV_D1;
         cht_pkg::STEP_DIV_D1:  return cht_pkg::STEP_DIV_D2;
         cht_pkg::STEP_DIV_D2:  return cht_pkg::STEP_DIV_D3;
         cht_pkg::STEP_DIV_D3:  return cht_pkg::STEP_PLAN;
         cht_pkg::STEP_MUL_T2:  return cht_pkg::STEP_MUL_T3;
         cht_pkg::STEP_MUL_T3:  return cht_pkg::STEP_MUL_M1;
         cht_pkg::STEP_MUL_M1:  return cht_pkg::STEP_MUL_M2;
         cht_pkg::STEP_MUL_M2:  return cht_pkg::STEP_MUL_M3;
         cht_pkg::STEP_MUL_M3:  return cht_pkg::STEP_MUL_M4;
         cht_pkg::STEP_MUL_M4:  return cht_pkg::STEP_EVAL;
         default:               return cht_pkg::STEP_OUT;
      endcase
   endfunction

   function automatic logic is_unit(input cht_pkg::step_type s);
      case (s)
         cht_pkg::STEP_DIV_DUR, cht_pkg::STEP_DIV_C1, cht_pkg::STEP_DIV_C2,
         cht_pkg::STEP_DIV_D1, cht_pkg::STEP_DIV_D2, cht_pkg::STEP_DIV_D3,
         cht_pkg::STEP_MUL_T2, cht_pkg::STEP_MUL_T3, cht_pkg::STEP_MUL_M1,
         cht_pkg::STEP_MUL_M2, cht_pkg::STEP_MUL_M3, cht_pkg::STEP_MUL_M4:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   state_type         state_ff, state_in;
   cht_pkg::step_type step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              unit_go;
   logic              out_go;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.step     = step_ff;
      cmd.go       = 1'b0;
      cmd.load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_ISSUE;
            if (!st.op)
               step_in = cht_pkg::STEP_DELTA;
            else if (!st.active)
               step_in = cht_pkg::STEP_OUT;
            else if (st.edge_hit)
               step_in = cht_pkg::STEP_EDGE;
            else if (st.timeout)
               step_in = cht_pkg::STEP_DELTA;
            else
               step_in = cht_pkg::STEP_MUL_T2;
         end
         S_ISSUE: begin
            if (step_ff == cht_pkg::STEP_OUT) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.go       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.go = 1'b1;
               if (is_unit(step_ff))
                  state_in = S_WAIT;
               else
                  step_in = next_step(step_ff);
            end
         end
         S_WAIT: begin
            if (st.done) begin
               step_in  = next_step(step_ff);
               state_in = S_ISSUE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= cht_pkg::STEP_OUT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign unit_go   = cmd.go & is_unit(cmd.step);
   assign out_go    = cmd.go & (cmd.step == cht_pkg::STEP_OUT);

   `ASSERT_NEXT(a_accept_decide, clock, reset, req_valid && req_ready, state_ff == S_DECIDE, "beat taken but no decide")
   `ASSERT_NEXT(a_unit_wait, clock, reset, unit_go, state_ff == S_WAIT, "unit started without wait")
   `ASSERT_SAME(a_done_in_wait, clock, reset, st.done, state_ff == S_WAIT, "unit done outside wait")
   `ASSERT_NEXT(a_out_valid, clock, reset, out_go, rsp_valid_ff && state_ff == S_IDLE, "result beat lost")

endmodule

// ===== sv/cubic_homing_trajectory.sv =====
// ---------------------------------------------------------------------------
// cubic_homing_trajectory
// cubic homing reference generator for one joint, Q16.16 fixed point
// ---------------------------------------------------------------------------
// channel  direction  content
// req_     in         op, switch level, joint position
// rsp_     out        ref position, ref velocity, busy, homed, clear encoder
// csr_     in         register index and write data, always ready
//
// a start, or a tick that times out, plans with six 64 bit divisions. a tick
// that evaluates the cubic runs six 64 by 64 bit multiplies. an edge or idle
// tick uses neither the divider nor the multiplier.
// one beat in flight; a new beat is taken while the last result waits.
// synchronous reset restores the register defaults and clears the plan.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_homing_trajectory (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic               req_switch_level,
   input  logic signed [31:0] req_joint_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic               rsp_busy_res,
   output logic               rsp_homed,
   output logic               rsp_clear_encoder,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [25:0]        csr_data
);

   cht_pkg::cmd_type    cmd;
   cht_pkg::status_type st;

   assign csr_ready = 1'b1;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .st        (st)
   );

   cht_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_op             (req_op),
      .req_switch_level   (req_switch_level),
      .req_joint_position (req_joint_position),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_position       (rsp_position),
      .rsp_velocity       (rsp_velocity),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_homed          (rsp_homed),
      .rsp_clear_encoder  (rsp_clear_encoder)
   );

endmodule
